// ----- hdl/r250_pkg.sv -----
// r250 generator package: mode codes, fsm states, channel word types and constants
// no dependencies; used by r250_xor_shift_generator_top and r250_checker
`default_nettype none

package r250_pkg;

  // generator defaults
  localparam int unsigned TABLE_LEN_DEF    = 250;
  localparam int unsigned LAG_DEF          = 103;
  localparam int unsigned WARMUP_STEPS_DEF = 1000;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DRAW_W  = 15;
  localparam int unsigned SEED_N  = 32;   // diagonal words written at seed time
  localparam int unsigned DIAG_START = 3;
  localparam int unsigned DIAG_STRIDE = 7;

  localparam logic [WORD_W-1:0] DRAW_MASK  = 32'h0000_7fff;
  localparam logic [WORD_W-1:0] KEEP_INIT  = 32'hffff_ffff;
  localparam logic [WORD_W-1:0] FORCE_INIT = 32'h8000_0000;

  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_SEED   = 3'd1,
    MODE_RAW    = 3'd2,
    MODE_LOW15  = 3'd3,
    MODE_RANGED = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW_WR,
    ST_DIV,
    ST_EMIT,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_WARM_RD,
    ST_WARM_WR
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         index;
    logic [31:0]        value;
    logic signed [31:0] low;
    logic signed [31:0] high;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        word;
    logic signed [31:0] ranged;
  } out_word_t;

endpackage

`default_nettype wire

// ----- hdl/r250_stream_if.sv -----
// valid/ready stream channel carrying one word of a given payload type
// no dependencies; payload types come from r250_pkg at instantiation
`default_nettype none

interface r250_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/r250_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module r250_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/r250_xor_shift_generator_top.sv -----
// r250 lagged xor generator: table in two mirrored rams, fsm for draw, seed and warm-up
// depends on r250_pkg, r250_stream_if and r250_ram
//
// usage
//   in_i carries one command word (mode, index, value, low, high); out_o returns one
//   result word (word, ranged) for each draw command (modes 2, 3, 4) and nothing for
//   load (0), seed (1) or unused codes (5 to 7).
//   software first loads every table entry with mode 0 (in_i stays ready), then
//   issues mode 1, which writes the bit diagonal with 32 read-modify-write steps and
//   then runs WARMUP_STEPS silent draws; in_i is held not ready until the warm-up
//   is done.
//   a draw reads both lagged entries in the accept cycle (one read port per ram copy),
//   writes the xor back the next cycle and hands the result to the output register
//   from the emit state once that register is free.
//   a ranged draw whose range fits in 15 bits runs a bit-serial remainder unit over
//   the 15 draw bits before it emits; a wider range costs no extra time, and low >=
//   high skips the draw.
//   one command is worked on at a time; the next is taken while a result still waits
//   in the output register, and a new result waits in its own state until that
//   register is free, so a stalled receiver loses nothing.
//   reset clears the indices to 0 and LAG mod TABLE_LEN; the table holds garbage until
//   it is loaded.
`default_nettype none

module r250_xor_shift_generator_top #(
  parameter int unsigned TABLE_LEN    = r250_pkg::TABLE_LEN_DEF,
  parameter int unsigned LAG          = r250_pkg::LAG_DEF,
  parameter int unsigned WARMUP_STEPS = r250_pkg::WARMUP_STEPS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  r250_stream_if.sink       in_i,
  r250_stream_if.source     out_o
);

  localparam int unsigned IW = $clog2(TABLE_LEN);
  localparam int unsigned WW = $clog2(WARMUP_STEPS + 2);
  localparam int unsigned KW = $clog2(r250_pkg::SEED_N);
  localparam int unsigned CW = $clog2(r250_pkg::DRAW_W);

  localparam logic [IW-1:0] SECOND_INIT = IW'(LAG % TABLE_LEN);
  localparam logic [IW-1:0] POS_INIT    = IW'(r250_pkg::DIAG_START % TABLE_LEN);
  localparam logic [IW:0]   POS_STEP    = (IW+1)'(r250_pkg::DIAG_STRIDE % TABLE_LEN);
  localparam logic [IW:0]   LEN_X       = (IW+1)'(TABLE_LEN);

  // circular increment mod table length
  function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx);
    logic [IW:0] nxt;
    nxt = {1'b0, idx} + (IW+1)'(1);
    return (nxt == LEN_X) ? '0 : nxt[IW-1:0];
  endfunction

  r250_pkg::state_e state_q, state_d;

  logic [IW-1:0] first_q, first_d;
  logic [IW-1:0] second_q, second_d;
  logic [IW-1:0] pos_q, pos_d;      // diagonal position
  logic [KW-1:0] k_q, k_d;          // diagonal step
  logic [WW-1:0] warm_q, warm_d;    // warm-up steps done
  logic [CW-1:0] div_cnt_q, div_cnt_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [2:0]  mode_q, mode_d;
  logic [31:0] lo_q, lo_d;
  logic [32:0] range_q, range_d;
  logic [14:0] dvd_q, dvd_d;
  logic [14:0] rem_q, rem_d;
  logic [31:0] res_word_q, res_word_d;
  logic [31:0] res_ranged_q, res_ranged_d;
  r250_pkg::out_word_t out_q, out_d;

  // ram control
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr_a;
  logic [31:0]   rd_a, rd_b;

  logic        in_acc;
  logic        out_free;
  logic        lo_ge_hi;
  logic        range_wide;
  logic [31:0] xor_w;
  logic [31:0] keep_w, force_w;
  logic [IW:0] pos_sum;
  logic [15:0] div_t;
  logic [14:0] rem_step;

  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign lo_ge_hi   = in_i.data.low >= in_i.data.high;
  assign range_wide = range_q[32:15] != '0;   // range above every 15-bit draw
  assign xor_w      = rd_a ^ rd_b;
  assign keep_w     = r250_pkg::KEEP_INIT >> k_q;
  assign force_w    = r250_pkg::FORCE_INIT >> k_q;
  assign pos_sum    = {1'b0, pos_q} + POS_STEP;

  // one restoring-division step, msb of the draw first
  always_comb begin
    div_t = {rem_q, dvd_q[14]};
    if (33'(div_t) >= range_q) begin
      rem_step = 15'(div_t - range_q[15:0]);
    end else begin
      rem_step = div_t[14:0];
    end
  end

  // two mirrored copies: a serves the first index (and seed), b the lagged one
  r250_ram #(.WIDTH(r250_pkg::WORD_W), .DEPTH(TABLE_LEN)) u_ram_a (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr_a),
    .rd_data_o (rd_a)
  );

  r250_ram #(.WIDTH(r250_pkg::WORD_W), .DEPTH(TABLE_LEN)) u_ram_b (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (second_q),
    .rd_data_o (rd_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      r250_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_i.data.mode)
            r250_pkg::MODE_SEED:   state_d = r250_pkg::ST_SEED_RD;
            r250_pkg::MODE_RAW,
            r250_pkg::MODE_LOW15:  state_d = r250_pkg::ST_DRAW_WR;
            r250_pkg::MODE_RANGED: state_d = lo_ge_hi ? r250_pkg::ST_EMIT
                                                      : r250_pkg::ST_DRAW_WR;
            default:               state_d = r250_pkg::ST_IDLE;
          endcase
        end
      end
      r250_pkg::ST_DRAW_WR: begin
        if (mode_q == r250_pkg::MODE_RANGED && !range_wide) begin
          state_d = r250_pkg::ST_DIV;
        end else begin
          state_d = r250_pkg::ST_EMIT;
        end
      end
      r250_pkg::ST_DIV: begin
        if (div_cnt_q == CW'(r250_pkg::DRAW_W - 1)) begin
          state_d = r250_pkg::ST_EMIT;
        end
      end
      r250_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = r250_pkg::ST_IDLE;
        end
      end
      r250_pkg::ST_SEED_RD: state_d = r250_pkg::ST_SEED_WR;
      r250_pkg::ST_SEED_WR: begin
        if (k_q == KW'(r250_pkg::SEED_N - 1)) begin
          state_d = (WARMUP_STEPS == 0) ? r250_pkg::ST_IDLE : r250_pkg::ST_WARM_RD;
        end else begin
          state_d = r250_pkg::ST_SEED_RD;
        end
      end
      r250_pkg::ST_WARM_RD: state_d = r250_pkg::ST_WARM_WR;
      r250_pkg::ST_WARM_WR: begin
        if (warm_q == WW'(WARMUP_STEPS - 1)) begin
          state_d = r250_pkg::ST_IDLE;
        end else begin
          state_d = r250_pkg::ST_WARM_RD;
        end
      end
      default: state_d = r250_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and ram control
  always_comb begin
    in_i.ready  = 1'b0;
    ram_re      = 1'b0;
    ram_raddr_a = first_q;
    ram_we      = 1'b0;
    ram_waddr   = first_q;
    ram_wdata   = xor_w;
    unique case (state_q)
      r250_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        ram_re     = 1'b1;   // lagged pair for a draw accepted now
        if (in_acc && in_i.data.mode == r250_pkg::MODE_LOAD
            && 32'(in_i.data.index) < 32'(TABLE_LEN)) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(in_i.data.index);
          ram_wdata = in_i.data.value;
        end
      end
      r250_pkg::ST_DRAW_WR,
      r250_pkg::ST_WARM_WR: ram_we = 1'b1;
      r250_pkg::ST_SEED_RD: begin
        ram_re      = 1'b1;
        ram_raddr_a = pos_q;
      end
      r250_pkg::ST_SEED_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = (rd_a & keep_w) | force_w;
      end
      r250_pkg::ST_WARM_RD: ram_re = 1'b1;
      default: ;
    endcase
  end

  // datapath and counters
  always_comb begin
    first_d      = first_q;
    second_d     = second_q;
    pos_d        = pos_q;
    k_d          = k_q;
    warm_d       = warm_q;
    div_cnt_d    = div_cnt_q;
    mode_d       = mode_q;
    lo_d         = lo_q;
    range_d      = range_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    res_word_d   = res_word_q;
    res_ranged_d = res_ranged_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    case (state_q)
      r250_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_d  = in_i.data.mode;
          lo_d    = in_i.data.low;
          range_d = {in_i.data.high[31], in_i.data.high}
                  - {in_i.data.low[31], in_i.data.low} + 33'd1;
          pos_d   = POS_INIT;
          k_d     = '0;
          // empty range: no draw, result ready at once
          res_word_d   = '0;
          res_ranged_d = in_i.data.low;
        end
      end
      r250_pkg::ST_DRAW_WR: begin
        first_d      = advance(first_q);
        second_d     = advance(second_q);
        res_word_d   = (mode_q == r250_pkg::MODE_LOW15) ? (xor_w & r250_pkg::DRAW_MASK)
                                                        : xor_w;
        res_ranged_d = (mode_q == r250_pkg::MODE_RANGED) ? lo_q + {17'd0, xor_w[14:0]}
                                                         : '0;
        dvd_d        = xor_w[14:0];
        rem_d        = '0;
        div_cnt_d    = '0;
      end
      r250_pkg::ST_DIV: begin
        rem_d        = rem_step;
        dvd_d        = {dvd_q[13:0], 1'b0};
        div_cnt_d    = div_cnt_q + CW'(1);
        res_ranged_d = lo_q + {17'd0, rem_step};
      end
      r250_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.word   = res_word_q;
          out_d.ranged = res_ranged_q;
        end
      end
      r250_pkg::ST_SEED_WR: begin
        k_d   = k_q + KW'(1);
        pos_d = (pos_sum >= LEN_X) ? IW'(pos_sum - LEN_X) : pos_sum[IW-1:0];
        if (k_q == KW'(r250_pkg::SEED_N - 1)) begin
          first_d  = '0;
          second_d = SECOND_INIT;
          warm_d   = '0;
        end
      end
      r250_pkg::ST_WARM_WR: begin
        first_d  = advance(first_q);
        second_d = advance(second_q);
        warm_d   = warm_q + WW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= r250_pkg::ST_IDLE;
      first_q     <= '0;
      second_q    <= SECOND_INIT;
      pos_q       <= POS_INIT;
      k_q         <= '0;
      warm_q      <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      second_q    <= second_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      warm_q      <= warm_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    lo_q         <= lo_d;
    range_q      <= range_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    res_word_q   <= res_word_d;
    res_ranged_q <= res_ranged_d;
    out_q        <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ----- hdl/r250_checker.sv -----
// port-level checks for the r250 generator, bound to its top level
// depends on r250_pkg and r250_xor_shift_generator_top
`default_nettype none

module r250_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic [2:0]          in_mode_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire r250_pkg::out_word_t out_data_i
);

  logic in_acc;
  logic work_mode;

  assign in_acc    = in_valid_i && in_ready_i;
  assign work_mode = in_mode_i == r250_pkg::MODE_SEED || in_mode_i == r250_pkg::MODE_RAW
                  || in_mode_i == r250_pkg::MODE_LOW15 || in_mode_i == r250_pkg::MODE_RANGED;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed or dropped under stall");

  // seed and draw commands close the input right after they are accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && work_mode |=> !in_ready_i)
    else $error("input reopened right after a working command");

  // a table load leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_mode_i == r250_pkg::MODE_LOAD |=> in_ready_i)
    else $error("input closed after a table load");

  // a fresh result only shows up while the generator is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i && !out_ready_i) |-> $past(!in_ready_i))
    else $error("result appeared without a command in flight");

endmodule

bind r250_xor_shift_generator_top r250_checker u_r250_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.data.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
